### src/assert_macros.svh
// assertion macros shared by the observer frame rotation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define OFR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ofr assertion failed");

// next-cycle implication
`define OFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ofr assertion failed");

`endif

### src/ofr_pkg.sv
// shared constants and codes of the observer frame rotation block
package ofr_pkg;

  // normalized direction magnitude lies in [2^(NORM_BITS-1), 2^NORM_BITS)
  localparam int unsigned NORM_BITS = 28;
  // sum of squares of the normalized direction
  localparam int unsigned SQ_BITS   = 2 * NORM_BITS + 1;
  // floor square root of that sum
  localparam int unsigned ROOT_BITS = NORM_BITS + 1;

  typedef enum logic [0:0] {
    CFG_CENTER_X = 1'b0,
    CFG_CENTER_Y = 1'b1
  } cfg_idx_e;

endpackage

### src/ofr_front.sv
// front stages: offsets, direction normalization, products and sums
`include "assert_macros.svh"

module ofr_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  logic signed [COORD_BITS-1:0]                     object_x_i,
  input  logic signed [COORD_BITS-1:0]                     object_y_i,
  input  logic signed [COORD_BITS-1:0]                     agent_x_i,
  input  logic signed [COORD_BITS-1:0]                     agent_y_i,
  input  logic signed [COORD_BITS-1:0]                     center_x_i,
  input  logic signed [COORD_BITS-1:0]                     center_y_i,
  output logic                                             valid_o,
  output logic                                             zero_o,
  output logic        [COORD_BITS-1:0]                     zero_rel_x_o,
  output logic        [COORD_BITS-1:0]                     zero_rel_y_o,
  output logic        [ofr_pkg::SQ_BITS-1:0]               sq_o,
  output logic signed [COORD_BITS+ofr_pkg::NORM_BITS+2:0]  cross_o,
  output logic signed [COORD_BITS+ofr_pkg::NORM_BITS+2:0]  dot_o
);
  import ofr_pkg::*;

  localparam int unsigned AW    = COORD_BITS + 1;
  localparam int unsigned AW1   = AW + 1;
  localparam int unsigned NW    = NORM_BITS + 1;
  localparam int unsigned PW    = AW + NW;
  localparam int unsigned PSQ   = 2 * NW;
  localparam int unsigned NUM_W = PW + 1;
  localparam int unsigned SHW   = $clog2(AW + 1);
  localparam int unsigned FW    = AW + NORM_BITS;

  function automatic logic [COORD_BITS-1:0] sat_fn(input logic signed [AW:0] v);
    logic [COORD_BITS-1:0] r;
    if ((&v[AW:COORD_BITS-1]) || !(|v[AW:COORD_BITS-1])) begin
      r = v[COORD_BITS-1:0];
    end else if (v[AW]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  logic [4:0] vld_q;

  // stage 1
  logic signed [AW-1:0] ax1_q, ay1_q, dx1_q, dy1_q;
  // stage 2
  logic [AW-1:0]         mx2_q, my2_q, mx2_d, my2_d;
  logic                  sx2_q, sy2_q, zero2_q, zero2_d;
  logic [SHW-1:0]        sh2_q, sh2_d;
  logic [COORD_BITS-1:0] zrx2_q, zry2_q;
  logic signed [AW-1:0]  dx2_q, dy2_q;
  logic [AW-1:0]         m2;
  // stage 3
  logic [FW-1:0]         fx3, fy3;
  logic signed [NW-1:0]  ux3, uy3, ax3_q, ay3_q, ax3_d, ay3_d;
  logic                  zero3_q;
  logic [COORD_BITS-1:0] zrx3_q, zry3_q;
  logic signed [AW-1:0]  dx3_q, dy3_q;
  // stage 4
  logic signed [PSQ-1:0] pxx4_q, pyy4_q;
  logic signed [PW-1:0]  c14_q, c24_q, d14_q, d24_q;
  logic                  zero4_q;
  logic [COORD_BITS-1:0] zrx4_q, zry4_q;
  // stage 5
  logic [SQ_BITS-1:0]      sq5_q;
  logic signed [NUM_W-1:0] cross5_q, dot5_q;
  logic                    zero5_q;
  logic [COORD_BITS-1:0]   zrx5_q, zry5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // leading one of the larger magnitude gives the normalizing shift
  always_comb begin
    mx2_d = ax1_q[AW-1] ? AW'(-ax1_q) : AW'(ax1_q);
    my2_d = ay1_q[AW-1] ? AW'(-ay1_q) : AW'(ay1_q);
    m2    = mx2_d | my2_d;
    sh2_d = '0;
    for (int i = 0; i < AW; i++) begin
      if (m2[i]) begin
        sh2_d = SHW'(i + 1);
      end
    end
    zero2_d = (m2 == '0);
  end

  // mag * 2^(NORM_BITS-1-msb), truncated toward zero
  always_comb begin
    fx3   = {mx2_q, {NORM_BITS{1'b0}}} >> sh2_q;
    fy3   = {my2_q, {NORM_BITS{1'b0}}} >> sh2_q;
    ux3   = $signed({1'b0, fx3[NORM_BITS-1:0]});
    uy3   = $signed({1'b0, fy3[NORM_BITS-1:0]});
    ax3_d = sx2_q ? -ux3 : ux3;
    ay3_d = sy2_q ? -uy3 : uy3;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q    <= AW'(agent_x_i) - AW'(center_x_i);
      ay1_q    <= AW'(agent_y_i) - AW'(center_y_i);
      dx1_q    <= AW'(object_x_i) - AW'(agent_x_i);
      dy1_q    <= AW'(object_y_i) - AW'(agent_y_i);

      mx2_q    <= mx2_d;
      my2_q    <= my2_d;
      sx2_q    <= ax1_q[AW-1];
      sy2_q    <= ay1_q[AW-1];
      sh2_q    <= sh2_d;
      zero2_q  <= zero2_d;
      zrx2_q   <= sat_fn(AW1'(dy1_q));
      zry2_q   <= sat_fn(-AW1'(dx1_q));
      dx2_q    <= dx1_q;
      dy2_q    <= dy1_q;

      ax3_q    <= ax3_d;
      ay3_q    <= ay3_d;
      zero3_q  <= zero2_q;
      zrx3_q   <= zrx2_q;
      zry3_q   <= zry2_q;
      dx3_q    <= dx2_q;
      dy3_q    <= dy2_q;

      pxx4_q   <= PSQ'(ax3_q) * PSQ'(ax3_q);
      pyy4_q   <= PSQ'(ay3_q) * PSQ'(ay3_q);
      c14_q    <= PW'(dy3_q) * PW'(ax3_q);
      c24_q    <= PW'(dx3_q) * PW'(ay3_q);
      d14_q    <= PW'(dx3_q) * PW'(ax3_q);
      d24_q    <= PW'(dy3_q) * PW'(ay3_q);
      zero4_q  <= zero3_q;
      zrx4_q   <= zrx3_q;
      zry4_q   <= zry3_q;

      sq5_q    <= SQ_BITS'(pxx4_q + pyy4_q);
      cross5_q <= NUM_W'(c14_q) - NUM_W'(c24_q);
      dot5_q   <= NUM_W'(d14_q) + NUM_W'(d24_q);
      zero5_q  <= zero4_q;
      zrx5_q   <= zrx4_q;
      zry5_q   <= zry4_q;
    end
  end

  assign valid_o      = vld_q[4];
  assign zero_o       = zero5_q;
  assign zero_rel_x_o = zrx5_q;
  assign zero_rel_y_o = zry5_q;
  assign sq_o         = sq5_q;
  assign cross_o      = cross5_q;
  assign dot_o        = dot5_q;

  `OFR_ASSERT(a_norm_range, vld_q[1] && !zero2_q, fx3[NORM_BITS-1] || fy3[NORM_BITS-1])
  `OFR_ASSERT(a_norm_fits, vld_q[1] && !zero2_q, (fx3 >> NORM_BITS) == '0)
  `OFR_ASSERT(a_sq_floor, vld_q[4] && !zero5_q, sq_o[SQ_BITS-1:2*NORM_BITS-2] != '0)

endmodule

### src/ofr_sqrt.sv
// pipelined floor square root, one result bit per stage
`include "assert_macros.svh"

module ofr_sqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ofr_pkg::SQ_BITS-1:0]   x_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [ofr_pkg::ROOT_BITS-1:0] root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import ofr_pkg::*;

  localparam int unsigned N  = ROOT_BITS;
  localparam int unsigned RW = SQ_BITS + 1;

  logic [N-1:0]         vld_q;
  logic [SQ_BITS-1:0]   rem_q  [N];
  logic [RW-1:0]        root_q [N];
  logic [SIDE_W-1:0]    side_q [N];
  logic [SQ_BITS-1:0]   rem_in [N];
  logic [RW-1:0]        root_in[N];
  logic [SIDE_W-1:0]    side_in[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  for (genvar gi = 0; gi < N; gi++) begin : g_stage
    localparam int unsigned SH = 2 * (N - 1 - gi);
    logic [RW-1:0]      bit_w, trial;
    logic               take;
    logic [SQ_BITS-1:0] rem_d;
    logic [RW-1:0]      root_d;

    if (gi == 0) begin : g_first
      assign rem_in[gi]  = x_i;
      assign root_in[gi] = '0;
      assign side_in[gi] = side_i;
    end else begin : g_next
      assign rem_in[gi]  = rem_q[gi-1];
      assign root_in[gi] = root_q[gi-1];
      assign side_in[gi] = side_q[gi-1];
    end

    always_comb begin
      bit_w  = RW'(1) << SH;
      trial  = root_in[gi] + bit_w;
      take   = RW'(rem_in[gi]) >= trial;
      rem_d  = take ? (rem_in[gi] - trial[SQ_BITS-1:0]) : rem_in[gi];
      root_d = take ? ((root_in[gi] >> 1) + bit_w) : (root_in[gi] >> 1);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi]  <= rem_d;
        root_q[gi] <= root_d;
        side_q[gi] <= side_in[gi];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1][ROOT_BITS-1:0];
  assign side_o  = side_q[N-1];

  // remainder x - root^2 never exceeds 2*root
  `OFR_ASSERT(a_sqrt_rem, vld_q[N-1], RW'(rem_q[N-1]) <= (root_q[N-1] << 1))
  `OFR_ASSERT(a_sqrt_width, vld_q[N-1], (root_q[N-1] >> ROOT_BITS) == '0)

endmodule

### src/ofr_div.sv
// pipelined restoring divider for two numerators sharing one divisor
`include "assert_macros.svh"

module ofr_div #(
  parameter int unsigned NUM_W  = 47,
  parameter int unsigned QB     = 18,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ofr_pkg::ROOT_BITS-1:0] den_i,
  input  logic [NUM_W-1:0]              num_a_i,
  input  logic [NUM_W-1:0]              num_b_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [QB-1:0]                 q_a_o,
  output logic [QB-1:0]                 q_b_o,
  output logic [SIDE_W-1:0]             side_o
);
  import ofr_pkg::*;

  localparam int unsigned DW = (NUM_W > ROOT_BITS + QB) ? NUM_W : ROOT_BITS + QB;

  logic [QB-1:0]        vld_q;
  logic [DW-1:0]        ra_q  [QB];
  logic [DW-1:0]        rb_q  [QB];
  logic [QB-1:0]        qa_q  [QB];
  logic [QB-1:0]        qb_q  [QB];
  logic [ROOT_BITS-1:0] den_q [QB];
  logic [SIDE_W-1:0]    side_q[QB];

  logic [DW-1:0]        ra_in  [QB];
  logic [DW-1:0]        rb_in  [QB];
  logic [QB-1:0]        qa_in  [QB];
  logic [QB-1:0]        qb_in  [QB];
  logic [ROOT_BITS-1:0] den_in [QB];
  logic [SIDE_W-1:0]    side_in[QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-2:0], valid_i};
    end
  end

  for (genvar gi = 0; gi < QB; gi++) begin : g_stage
    localparam int unsigned SH = QB - 1 - gi;
    logic [DW-1:0] dsh, ra_d, rb_d;
    logic          ta, tb;

    if (gi == 0) begin : g_first
      assign ra_in[gi]   = DW'(num_a_i);
      assign rb_in[gi]   = DW'(num_b_i);
      assign qa_in[gi]   = '0;
      assign qb_in[gi]   = '0;
      assign den_in[gi]  = den_i;
      assign side_in[gi] = side_i;
    end else begin : g_next
      assign ra_in[gi]   = ra_q[gi-1];
      assign rb_in[gi]   = rb_q[gi-1];
      assign qa_in[gi]   = qa_q[gi-1];
      assign qb_in[gi]   = qb_q[gi-1];
      assign den_in[gi]  = den_q[gi-1];
      assign side_in[gi] = side_q[gi-1];
    end

    always_comb begin
      dsh  = DW'(den_in[gi]) << SH;
      ta   = ra_in[gi] >= dsh;
      tb   = rb_in[gi] >= dsh;
      ra_d = ta ? (ra_in[gi] - dsh) : ra_in[gi];
      rb_d = tb ? (rb_in[gi] - dsh) : rb_in[gi];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[gi]   <= ra_d;
        rb_q[gi]   <= rb_d;
        qa_q[gi]   <= {qa_in[gi][QB-2:0], ta};
        qb_q[gi]   <= {qb_in[gi][QB-2:0], tb};
        den_q[gi]  <= den_in[gi];
        side_q[gi] <= side_in[gi];
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign q_a_o   = qa_q[QB-1];
  assign q_b_o   = qb_q[QB-1];
  assign side_o  = side_q[QB-1];

  // quotient fits QB bits, so the final remainders are below the divisor
  `OFR_ASSERT(a_div_rem_a, vld_q[QB-1] && (den_q[QB-1] != '0),
              ra_q[QB-1] < DW'(den_q[QB-1]))
  `OFR_ASSERT(a_div_rem_b, vld_q[QB-1] && (den_q[QB-1] != '0),
              rb_q[QB-1] < DW'(den_q[QB-1]))

endmodule

### src/observer_frame_rotation.sv
// top level of the observer frame rotation block
//
// Rotates an object position into the frame of an agent that faces the table
// centre. Input transactions on s_axis carry object and agent positions; one
// output transaction on m_axis carries rel_x and rel_y, signed, saturated.
// The table centre is set through cfg_we_i / cfg_idx_i / cfg_data_i (index 0
// centre x, index 1 centre y, both reset to zero); the user must set it only
// while the block is idle, as the block itself does not enforce this.
// From input to output register: five front stages (offsets, normalization,
// multipliers, sums), a 29 stage square root, one rounding prep stage, a
// divider with one quotient bit per stage, and the output register.
// Throughput is one transaction per cycle while m_axis_tready does not stall it.
// All stages advance together when the output register is empty or taken;
// while the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline and s_axis_tready hold, and nothing is lost or repeated.
// Reset clears all valid bits and the centre registers.
`include "assert_macros.svh"

module observer_frame_rotation #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic                                       cfg_idx_i,
  input  logic [COORD_BITS-1:0]                      cfg_data_i,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // object_x, object_y, agent_x, agent_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // rel_x, rel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_axis_tdata
);
  import ofr_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned NUM_W  = CB + NORM_BITS + 3;
  localparam int unsigned QB     = CB + 2;
  localparam int unsigned VW     = QB + 1;
  localparam int unsigned OUT_W  = ((2 * CB + 7) / 8) * 8;
  localparam int unsigned SIDE1  = 1 + 2 * CB + 2 * NUM_W;
  localparam int unsigned SIDE2  = 1 + 2 * CB + 2;

  function automatic logic [CB-1:0] sat_fn(input logic signed [VW-1:0] v);
    logic [CB-1:0] r;
    if ((&v[VW-1:CB-1]) || !(|v[VW-1:CB-1])) begin
      r = v[CB-1:0];
    end else if (v[VW-1]) begin
      r = {1'b1, {(CB-1){1'b0}}};
    end else begin
      r = {1'b0, {(CB-1){1'b1}}};
    end
    return r;
  endfunction

  logic                 en;
  logic signed [CB-1:0] center_x_q, center_y_q;

  // front
  logic                    f_vld, f_zero;
  logic [CB-1:0]           f_zrx, f_zry;
  logic [SQ_BITS-1:0]      f_sq;
  logic signed [NUM_W-1:0] f_cross, f_dot;

  // square root
  logic                    r_vld;
  logic [ROOT_BITS-1:0]    r_root;
  logic [SIDE1-1:0]        r_side;
  logic                    r_zero;
  logic [CB-1:0]           r_zrx, r_zry;
  logic signed [NUM_W-1:0] r_cross, r_dot;
  logic [NUM_W-1:0]        r_mag_a, r_mag_b;

  // rounding prep
  logic                 p_vld_q;
  logic [ROOT_BITS-1:0] p_den_q;
  logic [NUM_W-1:0]     p_num_a_q, p_num_b_q;
  logic [SIDE2-1:0]     p_side_q;

  // divider
  logic             d_vld;
  logic [QB-1:0]    d_qa, d_qb;
  logic [SIDE2-1:0] d_side;
  logic             d_zero, d_neg_a, d_neg_b;
  logic [CB-1:0]    d_zrx, d_zry;
  logic signed [VW-1:0] va, vb;
  logic [CB-1:0]    rel_x_d, rel_y_d;

  // output register
  logic             out_vld_q;
  logic [CB-1:0]    rel_x_q, rel_y_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ofr_front #(
    .COORD_BITS(CB)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .object_x_i  (s_axis_tdata[CB-1:0]),
    .object_y_i  (s_axis_tdata[2*CB-1:CB]),
    .agent_x_i   (s_axis_tdata[3*CB-1:2*CB]),
    .agent_y_i   (s_axis_tdata[4*CB-1:3*CB]),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .valid_o     (f_vld),
    .zero_o      (f_zero),
    .zero_rel_x_o(f_zrx),
    .zero_rel_y_o(f_zry),
    .sq_o        (f_sq),
    .cross_o     (f_cross),
    .dot_o       (f_dot)
  );

  ofr_sqrt #(
    .SIDE_W(SIDE1)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(f_vld),
    .x_i    (f_sq),
    .side_i ({f_zero, f_zrx, f_zry, f_cross, f_dot}),
    .valid_o(r_vld),
    .root_o (r_root),
    .side_o (r_side)
  );

  assign {r_zero, r_zrx, r_zry, r_cross, r_dot} = r_side;
  assign r_mag_a = r_cross[NUM_W-1] ? NUM_W'(-r_cross) : NUM_W'(r_cross);
  assign r_mag_b = r_dot[NUM_W-1] ? NUM_W'(-r_dot) : NUM_W'(r_dot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= r_vld;
    end
  end

  // half the divisor added for round half away from zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_den_q   <= r_root;
      p_num_a_q <= r_mag_a + NUM_W'(r_root >> 1);
      p_num_b_q <= r_mag_b + NUM_W'(r_root >> 1);
      p_side_q  <= {r_zero, r_zrx, r_zry, r_cross[NUM_W-1], !r_dot[NUM_W-1]};
    end
  end

  ofr_div #(
    .NUM_W (NUM_W),
    .QB    (QB),
    .SIDE_W(SIDE2)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(p_vld_q),
    .den_i  (p_den_q),
    .num_a_i(p_num_a_q),
    .num_b_i(p_num_b_q),
    .side_i (p_side_q),
    .valid_o(d_vld),
    .q_a_o  (d_qa),
    .q_b_o  (d_qb),
    .side_o (d_side)
  );

  assign {d_zero, d_zrx, d_zry, d_neg_a, d_neg_b} = d_side;

  always_comb begin
    va      = d_neg_a ? -$signed({1'b0, d_qa}) : $signed({1'b0, d_qa});
    vb      = d_neg_b ? -$signed({1'b0, d_qb}) : $signed({1'b0, d_qb});
    rel_x_d = d_zero ? d_zrx : sat_fn(va);
    rel_y_d = d_zero ? d_zry : sat_fn(vb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rel_x_q <= rel_x_d;
      rel_y_q <= rel_y_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({rel_y_q, rel_x_q});

  // a non-degenerate direction always yields a divisor of at least 2^(NORM_BITS-1)
  `OFR_ASSERT(a_den_nonzero, p_vld_q && !p_side_q[SIDE2-1], p_den_q[ROOT_BITS-1:NORM_BITS-1] != '0)
  // a stalled result stays in the output register
  `OFR_ASSERT_NEXT(a_out_hold, out_vld_q && !m_axis_tready, out_vld_q && $stable(rel_x_q))
  `OFR_ASSERT(a_stall_blocks_input, out_vld_q && !m_axis_tready, !s_axis_tready)

endmodule

### sim/tb_top.sv
// testbench of the observer frame rotation block: directed and random positions
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ofr_pkg::*;

  localparam int unsigned CB = 16;
  localparam int unsigned LATENCY = 54;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] agent_y;
    logic signed [CB-1:0] agent_x;
    logic signed [CB-1:0] object_y;
    logic signed [CB-1:0] object_x;
  } position_t;

  typedef struct packed {
    logic signed [CB-1:0] rel_y;
    logic signed [CB-1:0] rel_x;
  } rel_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CB-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  observer_frame_rotation #(.COORD_BITS(CB)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [CB-1:0] centre_x = '0, centre_y = '0;
  rel_pos_t expected_rel[$];
  int mismatches = 0, results_seen = 0, items_sent = 0;
  bit sender_idle_on = 1'b1, receiver_idle_on = 1'b1;
  int hold_off_cycles = 0;
  longint cycle_count = 0;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CB - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint floor_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint q;
    q = (mag(num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic rel_pos_t rotate_into_agent_frame(position_t p);
    longint ax, ay, dx, dy, m, n, cross_p, dot_p;
    rel_pos_t r;
    ax = longint'(p.agent_x) - longint'(centre_x);
    ay = longint'(p.agent_y) - longint'(centre_y);
    dx = longint'(p.object_x) - longint'(p.agent_x);
    dy = longint'(p.object_y) - longint'(p.agent_y);
    if (ax == 0 && ay == 0) begin
      // agent on the centre: quarter turn
      r.rel_x = CB'(sat(dy));
      r.rel_y = CB'(sat(-dx));
      return r;
    end
    m = mag(ax) > mag(ay) ? mag(ax) : mag(ay);
    while (m >= (64'sd1 <<< NORM_BITS)) begin
      ax = ax / 2;
      ay = ay / 2;
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< (NORM_BITS - 1))) begin
      ax = ax * 2;
      ay = ay * 2;
      m = m <<< 1;
    end
    n = floor_sqrt(ax * ax + ay * ay);
    cross_p = dy * ax - dx * ay;
    dot_p = dx * ax + dy * ay;
    r.rel_x = CB'(sat(round_div(cross_p, n)));
    r.rel_y = CB'(sat(-round_div(dot_p, n)));
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("observer_frame_rotation test failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rel_pos_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (expected_rel.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", got);
      end else begin
        want = expected_rel.pop_front();
        if (got.rel_x !== want.rel_x || got.rel_y !== want.rel_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch rel_x exp %0d got %0d, rel_y exp %0d got %0d",
                     want.rel_x, got.rel_x, want.rel_y, got.rel_y);
        end
      end
    end
  end

  // receiver stall: random bursts, or a long counted hold-off
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
        m_axis_tready <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 14);
        m_axis_tready <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // tvalid stays high after a transaction so the next one can follow directly
  task automatic send_position(position_t p);
    if (sender_idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    expected_rel = {expected_rel, rotate_into_agent_frame(p)};
    items_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_rel.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_centre(logic signed [CB-1:0] cx, logic signed [CB-1:0] cy);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CENTER_X;
    cfg_data_i <= cx;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CENTER_Y;
    cfg_data_i <= cy;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    centre_x = cx;
    centre_y = cy;
  endtask

  function automatic logic [CB-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return CB'($urandom_range(0, 64)) - 16'd32;
      default: return CB'($urandom());
    endcase
  endfunction

  task automatic test_directed_extremes();
    logic [CB-1:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    position_t p;
    // agent on the centre
    p = '{agent_y: 0, agent_x: 0, object_y: 16'h1000, object_x: 16'h0800};
    send_position(p);
    p = '{agent_y: 0, agent_x: 0, object_y: 16'h8000, object_x: 16'h8000};
    send_position(p);
    for (int i = 0; i < 20; i++) begin
      p.object_x = ext[i % 4];
      p.object_y = ext[(i / 4) % 4];
      p.agent_x = ext[(i + 1) % 4];
      p.agent_y = ext[(i / 2 + 3) % 4];
      send_position(p);
    end
  endtask

  task automatic test_random_positions(int count, bit agent_near_centre);
    position_t p;
    repeat (count) begin
      p.object_x = random_coord();
      p.object_y = random_coord();
      if (agent_near_centre && $urandom_range(0, 3) == 0) begin
        p.agent_x = centre_x;
        p.agent_y = centre_y;
      end else begin
        p.agent_x = random_coord();
        p.agent_y = random_coord();
      end
      send_position(p);
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 150;
    test_random_positions(80, 1'b0);
    // sender pauses until all results are back
    s_axis_tvalid <= 1'b0;
    while (expected_rel.size() != 0) @(posedge clk_i);
    test_random_positions(10, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    write_centre(16'h8000, 16'h7fff);
    test_random_positions(60, 1'b1);
    write_centre(16'h7fff, 16'h8000);
    test_random_positions(60, 1'b1);
    write_centre(16'h0400, 16'hfc00);
    test_backpressure();
    write_centre(CB'($urandom()), CB'($urandom()));
    test_random_positions(120, 1'b1);
    write_centre(16'h0000, 16'h0000);
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    test_random_positions(80, 1'b1);
    drain_results();
    $display("covered %0d positions under six table centres, with idle gaps and stalls",
             items_sent);
    $display("including a long receiver hold-off; %0d results compared", results_seen);
    if (mismatches == 0 && expected_rel.size() == 0) begin
      $display("observer_frame_rotation test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("observer_frame_rotation test failed");
    end
    $finish;
  end
endmodule
